// File: hw/rtl/tcphp_pkg.sv
package tcphp_pkg;

  // Fixed TCP header size in bytes and the default segment length limit.
  localparam int unsigned HDR_BYTES         = 20;
  localparam int unsigned MAX_SEG_BYTES_DEF = 65535;

  // Option kinds that the walker recognizes.
  localparam logic [7:0] OPT_KIND_EOL    = 8'd0;
  localparam logic [7:0] OPT_KIND_NOP    = 8'd1;
  localparam logic [7:0] OPT_KIND_MSS    = 8'd2;
  localparam logic [7:0] OPT_KIND_WSCALE = 8'd3;

  // Required option lengths, the length byte that is rejected, and the one that behaves as a no-op.
  localparam logic [7:0] OPT_LEN_ZERO   = 8'd0;
  localparam logic [7:0] OPT_LEN_ONE    = 8'd1;
  localparam logic [7:0] OPT_LEN_MSS    = 8'd4;
  localparam logic [7:0] OPT_LEN_WSCALE = 8'd3;

  // Width of the header length in bytes, and the option offset after reset.
  localparam int unsigned HLEN_W   = 6;
  localparam logic [5:0]  OPT_BASE = 6'd20;

  // Folded ones' complement sum of a good segment.
  localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_HDR_ERR  = 2'd1,
    STATUS_CSUM_ERR = 2'd2
  } status_t;

  // Option walker states, one-hot.
  typedef enum logic [5:0] {
    OPT_KIND   = 6'b000001,
    OPT_LEN    = 6'b000010,
    OPT_MSS_HI = 6'b000100,
    OPT_MSS_LO = 6'b001000,
    OPT_WS     = 6'b010000,
    OPT_DONE   = 6'b100000
  } opt_state_t;

endpackage

// File: hw/rtl/tcphp_seg_if.sv
// Byte stream channel: one pseudo header or segment byte per beat.
interface tcphp_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_pseudo;
  logic       last_byte;

  modport source (output valid, output data_byte, output in_pseudo, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input in_pseudo, input last_byte,
                output ready);
endinterface

// File: hw/rtl/tcphp_res_if.sv
// Result channel: one parsed header and status per beat.
interface tcphp_res_if;
  logic                  valid;
  logic                  ready;
  tcphp_pkg::status_t    status;
  logic [15:0]           source_port;
  logic [15:0]           dst_port;
  logic [31:0]           seq_num;
  logic [31:0]           ack_num;
  logic [5:0]            header_len;
  logic [5:0]            flag_bits;
  logic [15:0]           window;
  logic [15:0]           urgent_pointer;
  logic [1:0]            options_seen;
  logic [15:0]           max_seg_size;
  logic [7:0]            wscale_value;

  modport source (output valid, output status, output source_port, output dst_port,
                  output seq_num, output ack_num, output header_len, output flag_bits,
                  output window, output urgent_pointer, output options_seen,
                  output max_seg_size, output wscale_value, input ready);
  modport sink (input valid, input status, input source_port, input dst_port,
                input seq_num, input ack_num, input header_len, input flag_bits,
                input window, input urgent_pointer, input options_seen,
                input max_seg_size, input wscale_value, output ready);
endinterface

// File: hw/rtl/tcp_header_option_checksum_parser_unit.sv
// Channel  Dir  Beat content
// -------  ---  ------------------------------------------------------------
// seg      in   data_byte, in_pseudo, last_byte: one stream byte
// res      out  status and parsed header fields, one per segment
//
// A new byte can be accepted in every cycle while seg.ready is high. The result
// of a segment appears in the output register in the cycle after its last
// byte is accepted. Reset is synchronous and returns the parser to the start
// of a segment. seg.ready drops only while a result waits in the output
// register and res.ready is low.
module tcp_header_option_checksum_parser_unit #(
  parameter int unsigned MAX_SEGMENT_BYTES = tcphp_pkg::MAX_SEG_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tcphp_seg_if.sink    seg,
  tcphp_res_if.source  res
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENT_BYTES + 1);
  localparam int unsigned CMP_W = (IDX_W > 6) ? IDX_W : 6;

  // Parser state.
  logic [IDX_W-1:0]       byte_index, byte_index_next;
  logic [15:0]            sum_acc, sum_acc_next;
  logic                   odd_valid, odd_valid_next;
  logic [7:0]             odd_byte, odd_byte_next;
  tcphp_pkg::opt_state_t  opt_state, opt_state_next;
  logic [5:0]             opt_next, opt_next_next;
  logic [7:0]             opt_kind, opt_kind_next;
  logic                   error_flag, error_flag_next;

  // Header field registers.
  logic [15:0] source_port, source_port_next;
  logic [15:0] dst_port, dst_port_next;
  logic [31:0] seq_num, seq_num_next;
  logic [31:0] ack_num, ack_num_next;
  logic [3:0]  hdr_nibble, hdr_nibble_next;
  logic [5:0]  flag_bits, flag_bits_next;
  logic [15:0] window, window_next;
  logic [15:0] urgent_pointer, urgent_pointer_next;
  logic [1:0]  options_seen, options_seen_next;
  logic [15:0] max_seg_size, max_seg_size_next;
  logic [7:0]  wscale_value, wscale_value_next;

  // Output register.
  logic                  res_valid;
  tcphp_pkg::status_t    res_status;
  logic [15:0]           res_source_port, res_dst_port, res_window, res_urgent, res_mss;
  logic [31:0]           res_seq, res_ack;
  logic [5:0]            res_hlen, res_flags;
  logic [1:0]            res_opts;
  logic [7:0]            res_wscale;

  logic                  seg_fire;
  logic [7:0]            b;
  logic [CMP_W-1:0]      idx_c, hl_c, count_c;
  logic [5:0]            hl, hl_final, opt_i;
  logic [16:0]           csum_sum;
  logic [15:0]           csum_word;
  logic [8:0]            skip_next;
  logic                  final_err;
  tcphp_pkg::status_t    final_status;

  assign seg.ready = !res_valid || res.ready;
  assign seg_fire  = seg.valid && seg.ready;
  assign b         = seg.data_byte;

  assign idx_c = CMP_W'(byte_index);
  assign hl    = {hdr_nibble, 2'b00};
  assign hl_c  = CMP_W'(hl);
  assign opt_i = 6'(byte_index);

  // Checksum: pair bytes across the whole stream, pad an odd final byte.
  always_comb begin
    odd_valid_next = odd_valid;
    odd_byte_next  = odd_byte;
    csum_word      = {b, 8'h00};
    sum_acc_next   = sum_acc;
    if (odd_valid) begin
      csum_word = {odd_byte, b};
    end
    csum_sum = {1'b0, sum_acc} + {1'b0, csum_word};
    if (odd_valid || seg.last_byte) begin
      sum_acc_next   = csum_sum[15:0] + {15'd0, csum_sum[16]};
      odd_valid_next = 1'b0;
    end else begin
      odd_valid_next = 1'b1;
      odd_byte_next  = b;
    end
  end

  // Fixed header capture, byte counting and the option walk.
  always_comb begin
    byte_index_next     = byte_index;
    source_port_next    = source_port;
    dst_port_next       = dst_port;
    seq_num_next        = seq_num;
    ack_num_next        = ack_num;
    hdr_nibble_next     = hdr_nibble;
    flag_bits_next      = flag_bits;
    window_next         = window;
    urgent_pointer_next = urgent_pointer;
    options_seen_next   = options_seen;
    max_seg_size_next   = max_seg_size;
    wscale_value_next   = wscale_value;
    opt_state_next      = opt_state;
    opt_next_next       = opt_next;
    opt_kind_next       = opt_kind;
    error_flag_next     = error_flag;
    skip_next           = {3'd0, opt_i} - 9'd1 + {1'b0, b};

    if (!seg.in_pseudo) begin
      if (idx_c < CMP_W'(tcphp_pkg::HDR_BYTES)) begin
        case (5'(byte_index))
          5'd0:  source_port_next[15:8]    = b;
          5'd1:  source_port_next[7:0]     = b;
          5'd2:  dst_port_next[15:8]       = b;
          5'd3:  dst_port_next[7:0]        = b;
          5'd4:  seq_num_next[31:24]       = b;
          5'd5:  seq_num_next[23:16]       = b;
          5'd6:  seq_num_next[15:8]        = b;
          5'd7:  seq_num_next[7:0]         = b;
          5'd8:  ack_num_next[31:24]       = b;
          5'd9:  ack_num_next[23:16]       = b;
          5'd10: ack_num_next[15:8]        = b;
          5'd11: ack_num_next[7:0]         = b;
          5'd12: hdr_nibble_next           = b[7:4];
          5'd13: flag_bits_next            = b[5:0];
          5'd14: window_next[15:8]         = b;
          5'd15: window_next[7:0]          = b;
          5'd18: urgent_pointer_next[15:8] = b;
          5'd19: urgent_pointer_next[7:0]  = b;
          default: ;
        endcase
      end else if (idx_c < hl_c) begin
        // Option bytes; the position fits six bits inside the header.
        case (opt_state)
          tcphp_pkg::OPT_KIND: begin
            if (opt_i == opt_next) begin
              opt_kind_next = b;
              if (b == tcphp_pkg::OPT_KIND_EOL) begin
                opt_state_next = tcphp_pkg::OPT_DONE;
              end else if (b == tcphp_pkg::OPT_KIND_NOP) begin
                opt_next_next = opt_i + 6'd1;
              end else begin
                if (b == tcphp_pkg::OPT_KIND_MSS) options_seen_next[0] = 1'b1;
                if (b == tcphp_pkg::OPT_KIND_WSCALE) options_seen_next[1] = 1'b1;
                opt_state_next = tcphp_pkg::OPT_LEN;
              end
            end
          end
          tcphp_pkg::OPT_LEN: begin
            if (opt_kind == tcphp_pkg::OPT_KIND_MSS) begin
              if (b != tcphp_pkg::OPT_LEN_MSS || ({1'b0, opt_i} + 7'd2) >= {1'b0, hl}) begin
                error_flag_next = 1'b1;
                opt_state_next  = tcphp_pkg::OPT_DONE;
              end else begin
                max_seg_size_next = '0;
                opt_next_next     = opt_i + 6'd3;
                opt_state_next    = tcphp_pkg::OPT_MSS_HI;
              end
            end else if (opt_kind == tcphp_pkg::OPT_KIND_WSCALE) begin
              if (b != tcphp_pkg::OPT_LEN_WSCALE || ({1'b0, opt_i} + 7'd1) >= {1'b0, hl}) begin
                error_flag_next = 1'b1;
                opt_state_next  = tcphp_pkg::OPT_DONE;
              end else begin
                wscale_value_next = '0;
                opt_next_next     = opt_i + 6'd2;
                opt_state_next    = tcphp_pkg::OPT_WS;
              end
            end else if (b == tcphp_pkg::OPT_LEN_ZERO) begin
              error_flag_next = 1'b1;
              opt_state_next  = tcphp_pkg::OPT_DONE;
            end else if (b == tcphp_pkg::OPT_LEN_ONE) begin
              opt_next_next  = opt_i + 6'd1;
              opt_state_next = tcphp_pkg::OPT_KIND;
            end else if (skip_next > {3'd0, hl}) begin
              error_flag_next = 1'b1;
              opt_state_next  = tcphp_pkg::OPT_DONE;
            end else begin
              opt_next_next  = skip_next[5:0];
              opt_state_next = tcphp_pkg::OPT_KIND;
            end
          end
          tcphp_pkg::OPT_MSS_HI: begin
            max_seg_size_next[15:8] = b;
            opt_state_next          = tcphp_pkg::OPT_MSS_LO;
          end
          tcphp_pkg::OPT_MSS_LO: begin
            max_seg_size_next[7:0] = b;
            opt_state_next         = tcphp_pkg::OPT_KIND;
          end
          tcphp_pkg::OPT_WS: begin
            wscale_value_next = b;
            opt_state_next    = tcphp_pkg::OPT_KIND;
          end
          default: ;
        endcase
      end
      // The count saturates; later bytes still enter the checksum.
      if (byte_index < IDX_W'(MAX_SEGMENT_BYTES)) begin
        byte_index_next = byte_index + IDX_W'(1);
      end
    end
  end

  // Segment verdict, formed from the state including the last byte.
  assign hl_final = {hdr_nibble_next, 2'b00};
  assign count_c  = CMP_W'(byte_index_next);

  always_comb begin
    final_err = error_flag_next
             || count_c < CMP_W'(tcphp_pkg::HDR_BYTES)
             || hl_final < 6'(tcphp_pkg::HDR_BYTES)
             || CMP_W'(hl_final) > count_c
             || opt_state_next == tcphp_pkg::OPT_LEN
             || opt_state_next == tcphp_pkg::OPT_MSS_HI
             || opt_state_next == tcphp_pkg::OPT_MSS_LO
             || opt_state_next == tcphp_pkg::OPT_WS;
    if (final_err) begin
      final_status = tcphp_pkg::STATUS_HDR_ERR;
    end else if (sum_acc_next == tcphp_pkg::CSUM_GOOD) begin
      final_status = tcphp_pkg::STATUS_OK;
    end else begin
      final_status = tcphp_pkg::STATUS_CSUM_ERR;
    end
  end

  // State update; the last byte returns the parser to its start state.
  always_ff @(posedge clk) begin
    if (rst || (seg_fire && seg.last_byte)) begin
      byte_index     <= '0;
      sum_acc        <= '0;
      odd_valid      <= 1'b0;
      odd_byte       <= '0;
      opt_state      <= tcphp_pkg::OPT_KIND;
      opt_next       <= tcphp_pkg::OPT_BASE;
      opt_kind       <= '0;
      error_flag     <= 1'b0;
      source_port    <= '0;
      dst_port       <= '0;
      seq_num        <= '0;
      ack_num        <= '0;
      hdr_nibble     <= '0;
      flag_bits      <= '0;
      window         <= '0;
      urgent_pointer <= '0;
      options_seen   <= '0;
      max_seg_size   <= '0;
      wscale_value   <= '0;
    end else if (seg_fire) begin
      byte_index     <= byte_index_next;
      sum_acc        <= sum_acc_next;
      odd_valid      <= odd_valid_next;
      odd_byte       <= odd_byte_next;
      opt_state      <= opt_state_next;
      opt_next       <= opt_next_next;
      opt_kind       <= opt_kind_next;
      error_flag     <= error_flag_next;
      source_port    <= source_port_next;
      dst_port       <= dst_port_next;
      seq_num        <= seq_num_next;
      ack_num        <= ack_num_next;
      hdr_nibble     <= hdr_nibble_next;
      flag_bits      <= flag_bits_next;
      window         <= window_next;
      urgent_pointer <= urgent_pointer_next;
      options_seen   <= options_seen_next;
      max_seg_size   <= max_seg_size_next;
      wscale_value   <= wscale_value_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (seg_fire && seg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (seg_fire && seg.last_byte) begin
      res_status      <= final_status;
      res_source_port <= source_port_next;
      res_dst_port    <= dst_port_next;
      res_seq         <= seq_num_next;
      res_ack         <= ack_num_next;
      res_hlen        <= hl_final;
      res_flags       <= flag_bits_next;
      res_window      <= window_next;
      res_urgent      <= urgent_pointer_next;
      res_opts        <= options_seen_next;
      res_mss         <= max_seg_size_next;
      res_wscale      <= wscale_value_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.status         = res_status;
  assign res.source_port    = res_source_port;
  assign res.dst_port       = res_dst_port;
  assign res.seq_num        = res_seq;
  assign res.ack_num        = res_ack;
  assign res.header_len     = res_hlen;
  assign res.flag_bits      = res_flags;
  assign res.window         = res_window;
  assign res.urgent_pointer = res_urgent;
  assign res.options_seen   = res_opts;
  assign res.max_seg_size   = res_mss;
  assign res.wscale_value   = res_wscale;

`ifndef NO_ASSERTIONS
  // A last beat always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    seg_fire && seg.last_byte |=> res_valid)
    else $error("last beat did not produce a result");

  // A last beat returns the parser to the start of a segment.
  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    seg_fire && seg.last_byte |=> byte_index == '0 && !odd_valid
                                  && opt_state == tcphp_pkg::OPT_KIND)
    else $error("parser state not cleared after last beat");

  // A segment byte below the limit advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    seg_fire && !seg.last_byte && !seg.in_pseudo
    && byte_index < IDX_W'(MAX_SEGMENT_BYTES)
    |=> byte_index == $past(byte_index) + IDX_W'(1))
    else $error("byte count did not advance");
`endif

endmodule

// File: test/tb_tcp_header_option_checksum_parser_unit.sv
`default_nettype none

module tb_tcp_header_option_checksum_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int BACKPRESSURE_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    tcphp_pkg::status_t status;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  header_len;
    logic [5:0]  flag_bits;
    logic [15:0] window;
    logic [15:0] urgent_pointer;
    logic [1:0]  options_seen;
    logic [15:0] max_seg_size;
    logic [7:0]  wscale_value;
  } tcp_result_t;

  logic clk = 1'b0;
  logic rst;

  tcphp_seg_if seg ();
  tcphp_res_if res ();

  tcp_header_option_checksum_parser_unit DUT (
    .clk(clk),
    .rst(rst),
    .seg(seg),
    .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser state mirrored on the testbench side.
  int                     seg_count;
  logic [15:0]            csum_acc;
  logic [8:0]             csum_hold;
  logic [7:0]             hdr_bytes [20];
  tcphp_pkg::opt_state_t  opt_st;
  int                     opt_next;
  logic [7:0]             opt_kind;
  logic                   opt_err;
  logic [1:0]             opt_seen;
  logic [15:0]            opt_mss;
  logic [7:0]             opt_ws;

  tcp_result_t expected_hdrs [$];

  // Stimulus buffers for the stream under construction.
  logic [7:0] pseudo_buf [$];
  logic [7:0] seg_buf [$];
  logic [7:0] opt_buf [$];

  int src_idle_pct;
  int sink_idle_pct;
  int hold_cycles;
  int bytes_sent;
  int segments_sent;
  int results_checked;
  int mismatches;
  int hdr_good;
  int hdr_bad;
  int csum_bad;

  function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + 16'(s[16]);
  endfunction

  task automatic clear_parser();
    seg_count = 0;
    csum_acc  = '0;
    csum_hold = '0;
    foreach (hdr_bytes[k]) hdr_bytes[k] = '0;
    opt_st   = tcphp_pkg::OPT_KIND;
    opt_next = int'(tcphp_pkg::OPT_BASE);
    opt_kind = '0;
    opt_err  = 1'b0;
    opt_seen = '0;
    opt_mss  = '0;
    opt_ws   = '0;
  endtask

  task automatic opt_abort();
    opt_err = 1'b1;
    opt_st  = tcphp_pkg::OPT_DONE;
  endtask

  // Option walker: one header byte beyond the fixed part.
  task automatic walk_option(input int i, input logic [7:0] b, input int hl);
    int nxt;
    case (opt_st)
      tcphp_pkg::OPT_KIND: begin
        if (i == opt_next) begin
          opt_kind = b;
          if (b == tcphp_pkg::OPT_KIND_EOL) begin
            opt_st = tcphp_pkg::OPT_DONE;
          end else if (b == tcphp_pkg::OPT_KIND_NOP) begin
            opt_next = i + 1;
          end else begin
            if (b == tcphp_pkg::OPT_KIND_MSS) opt_seen[0] = 1'b1;
            if (b == tcphp_pkg::OPT_KIND_WSCALE) opt_seen[1] = 1'b1;
            opt_st = tcphp_pkg::OPT_LEN;
          end
        end
      end
      tcphp_pkg::OPT_LEN: begin
        if (opt_kind == tcphp_pkg::OPT_KIND_MSS) begin
          if (b != tcphp_pkg::OPT_LEN_MSS || i + 2 >= hl) begin
            opt_abort();
          end else begin
            opt_mss  = '0;
            opt_next = i + 3;
            opt_st   = tcphp_pkg::OPT_MSS_HI;
          end
        end else if (opt_kind == tcphp_pkg::OPT_KIND_WSCALE) begin
          if (b != tcphp_pkg::OPT_LEN_WSCALE || i + 1 >= hl) begin
            opt_abort();
          end else begin
            opt_ws   = '0;
            opt_next = i + 2;
            opt_st   = tcphp_pkg::OPT_WS;
          end
        end else if (b == tcphp_pkg::OPT_LEN_ZERO) begin
          opt_abort();
        end else if (b == tcphp_pkg::OPT_LEN_ONE) begin
          opt_next = i + 1;
          opt_st   = tcphp_pkg::OPT_KIND;
        end else begin
          nxt = i - 1 + int'(b);
          if (nxt > hl) begin
            opt_abort();
          end else begin
            opt_next = nxt;
            opt_st   = tcphp_pkg::OPT_KIND;
          end
        end
      end
      tcphp_pkg::OPT_MSS_HI: begin
        opt_mss[15:8] = b;
        opt_st = tcphp_pkg::OPT_MSS_LO;
      end
      tcphp_pkg::OPT_MSS_LO: begin
        opt_mss[7:0] = b;
        opt_st = tcphp_pkg::OPT_KIND;
      end
      tcphp_pkg::OPT_WS: begin
        opt_ws = b;
        opt_st = tcphp_pkg::OPT_KIND;
      end
      default: ;
    endcase
  endtask

  // Advance the parser mirror by one accepted byte; queue a header on the last one.
  task automatic predict_byte(input logic [7:0] b, input logic p, input logic l);
    int hl;
    logic err;
    tcp_result_t r;
    if (csum_hold[8]) begin
      csum_acc  = csum_add(csum_acc, {csum_hold[7:0], b});
      csum_hold = '0;
    end else begin
      csum_hold = {1'b1, b};
    end
    if (!p) begin
      if (seg_count < int'(tcphp_pkg::HDR_BYTES)) begin
        hdr_bytes[seg_count] = b;
      end else begin
        hl = int'(hdr_bytes[12][7:4]) * 4;
        if (seg_count < hl) walk_option(seg_count, b, hl);
      end
      if (seg_count < int'(tcphp_pkg::MAX_SEG_BYTES_DEF)) seg_count++;
    end
    if (l) begin
      hl  = int'(hdr_bytes[12][7:4]) * 4;
      err = opt_err || seg_count < int'(tcphp_pkg::HDR_BYTES)
            || hl < int'(tcphp_pkg::HDR_BYTES) || hl > seg_count;
      if (opt_st inside {tcphp_pkg::OPT_LEN, tcphp_pkg::OPT_MSS_HI, tcphp_pkg::OPT_MSS_LO,
                         tcphp_pkg::OPT_WS}) err = 1'b1;
      if (csum_hold[8]) csum_acc = csum_add(csum_acc, {csum_hold[7:0], 8'h00});
      if (err) r.status = tcphp_pkg::STATUS_HDR_ERR;
      else if (csum_acc == tcphp_pkg::CSUM_GOOD) r.status = tcphp_pkg::STATUS_OK;
      else r.status = tcphp_pkg::STATUS_CSUM_ERR;
      r.source_port    = {hdr_bytes[0], hdr_bytes[1]};
      r.dst_port       = {hdr_bytes[2], hdr_bytes[3]};
      r.seq_num        = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
      r.ack_num        = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
      r.header_len     = 6'(hl);
      r.flag_bits      = hdr_bytes[13][5:0];
      r.window         = {hdr_bytes[14], hdr_bytes[15]};
      r.urgent_pointer = {hdr_bytes[18], hdr_bytes[19]};
      r.options_seen   = opt_seen;
      r.max_seg_size   = opt_mss;
      r.wscale_value   = opt_ws;
      expected_hdrs.push_back(r);
      segments_sent++;
      clear_parser();
    end
  endtask

  // Offer one beat, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic p, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    seg.valid     <= 1'b1;
    seg.data_byte <= b;
    seg.in_pseudo <= p;
    seg.last_byte <= l;
    @(posedge clk);
    while (seg.ready !== 1'b1) @(posedge clk);
    predict_byte(b, p, l);
    bytes_sent++;
  endtask

  // Stop offering and let every outstanding header come out.
  task automatic wait_drained();
    seg.valid <= 1'b0;
    do @(posedge clk); while (expected_hdrs.size() != 0);
  endtask

  // Random option list of exactly n bytes; a broken list gets one random byte.
  task automatic make_options(input int n, input logic broken);
    int rem, pick, len, j;
    opt_buf.delete();
    while (opt_buf.size() < n) begin
      rem  = n - opt_buf.size();
      pick = $urandom_range(9);
      if (pick < 3) begin
        opt_buf.push_back(tcphp_pkg::OPT_KIND_NOP);
      end else if (pick < 5 && rem >= 4) begin
        opt_buf.push_back(tcphp_pkg::OPT_KIND_MSS);
        opt_buf.push_back(tcphp_pkg::OPT_LEN_MSS);
        opt_buf.push_back(8'($urandom_range(255)));
        opt_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 7 && rem >= 3) begin
        opt_buf.push_back(tcphp_pkg::OPT_KIND_WSCALE);
        opt_buf.push_back(tcphp_pkg::OPT_LEN_WSCALE);
        opt_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 9 && rem >= 2) begin
        len = $urandom_range(1, rem);
        opt_buf.push_back(8'($urandom_range(4, 255)));
        opt_buf.push_back(8'(len));
        for (j = 2; j < len; j++) opt_buf.push_back(8'($urandom_range(255)));
      end else begin
        opt_buf.push_back(tcphp_pkg::OPT_KIND_EOL);
        while (opt_buf.size() < n) opt_buf.push_back(8'($urandom_range(255)));
      end
    end
    if (broken && n > 0) opt_buf[$urandom_range(n - 1)] = 8'($urandom_range(255));
  endtask

  // Pseudo header plus a segment whose data offset is nib words; options come from opt_buf.
  task automatic build_segment(input int nib, input int np, input int payload);
    int hl, k;
    pseudo_buf.delete();
    seg_buf.delete();
    repeat (np) pseudo_buf.push_back(8'($urandom_range(255)));
    repeat (tcphp_pkg::HDR_BYTES) seg_buf.push_back(8'($urandom_range(255)));
    seg_buf[12] = {4'(nib), seg_buf[12][3:0]};
    hl = nib * 4;
    for (k = 0; k < hl - int'(tcphp_pkg::HDR_BYTES); k++) begin
      seg_buf.push_back(k < opt_buf.size() ? opt_buf[k] : tcphp_pkg::OPT_KIND_EOL);
    end
    repeat (payload) seg_buf.push_back(8'($urandom_range(255)));
  endtask

  // Send the buffered stream. The checksum field is set so the folded sum comes
  // out right; a bad checksum gets one of its bytes disturbed afterwards.
  task automatic send_stream(input logic csum_good);
    int np, ns, k, pos;
    logic [15:0] acc, w;
    logic [8:0] hold;
    logic [7:0] b;
    np = pseudo_buf.size();
    ns = seg_buf.size();
    if (ns >= 18) begin
      seg_buf[16] = '0;
      seg_buf[17] = '0;
      acc  = '0;
      hold = '0;
      for (k = 0; k < np + ns; k++) begin
        b = (k < np) ? pseudo_buf[k] : seg_buf[k - np];
        if (hold[8]) begin
          acc  = csum_add(acc, {hold[7:0], b});
          hold = '0;
        end else begin
          hold = {1'b1, b};
        end
      end
      if (hold[8]) acc = csum_add(acc, {hold[7:0], 8'h00});
      w   = ~acc;
      pos = np + 16;
      // On an odd stream offset the field straddles two words, so its bytes swap.
      if (pos % 2 == 0) begin
        seg_buf[16] = w[15:8];
        seg_buf[17] = w[7:0];
      end else begin
        seg_buf[16] = w[7:0];
        seg_buf[17] = w[15:8];
      end
      if (!csum_good) seg_buf[16] = seg_buf[16] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < np; k++) send_byte(pseudo_buf[k], 1'b1, ns == 0 && k == np - 1);
    for (k = 0; k < ns; k++) send_byte(seg_buf[k], 1'b0, k == ns - 1);
  endtask

  task automatic send_noise(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, k == n - 1);
    end
  endtask

  // Streams too short for a header, and a stream made of pseudo bytes only.
  task automatic test_short_and_pseudo();
    pseudo_buf.delete();
    seg_buf = '{8'hFF};
    send_stream(1'b1);
    pseudo_buf = '{8'h00, 8'hFF};
    seg_buf.delete();
    send_stream(1'b1);
    opt_buf.delete();
    build_segment(5, 0, 0);
    void'(seg_buf.pop_back());
    send_stream(1'b1);
  endtask

  // Header length below the fixed size, exact, and beyond the bytes sent.
  task automatic test_header_lengths();
    opt_buf.delete();
    build_segment(0, 12, 4);
    send_stream(1'b1);
    build_segment(4, 12, 4);
    send_stream(1'b1);
    build_segment(5, 11, 3);
    send_stream(1'b1);
    build_segment(5, 0, 0);
    send_stream(1'b1);
    make_options(40, 1'b0);
    build_segment(15, 12, 0);
    while (seg_buf.size() > 30) void'(seg_buf.pop_back());
    send_stream(1'b1);
  endtask

  task automatic test_options();
    opt_buf = '{tcphp_pkg::OPT_KIND_MSS, tcphp_pkg::OPT_LEN_MSS, 8'h05, 8'hB4,
                tcphp_pkg::OPT_KIND_NOP, tcphp_pkg::OPT_KIND_WSCALE,
                tcphp_pkg::OPT_LEN_WSCALE, 8'd14, tcphp_pkg::OPT_KIND_EOL};
    build_segment(8, 12, 2);
    send_stream(1'b1);
    // Wrong MSS length, reported as a header error even with a bad checksum.
    opt_buf = '{tcphp_pkg::OPT_KIND_MSS, 8'd5, 8'h05, 8'hB4};
    build_segment(6, 12, 1);
    send_stream(1'b0);
    opt_buf = '{tcphp_pkg::OPT_KIND_WSCALE, 8'd2, 8'd7, tcphp_pkg::OPT_KIND_NOP};
    build_segment(6, 12, 0);
    send_stream(1'b1);
    opt_buf = '{8'd8, tcphp_pkg::OPT_LEN_ZERO, 8'h00, 8'h00};
    build_segment(6, 12, 0);
    send_stream(1'b1);
    // A length of one behaves like a no-op and the walk goes on.
    opt_buf = '{8'd30, tcphp_pkg::OPT_LEN_ONE, tcphp_pkg::OPT_KIND_MSS,
                tcphp_pkg::OPT_LEN_MSS, 8'h12, 8'h34, tcphp_pkg::OPT_KIND_NOP,
                tcphp_pkg::OPT_KIND_EOL};
    build_segment(7, 12, 1);
    send_stream(1'b1);
    opt_buf = '{8'd19, 8'd20, 8'hAA, 8'h55};
    build_segment(6, 12, 0);
    send_stream(1'b1);
    // Option kind on the last header byte, its length never arrives.
    opt_buf = '{tcphp_pkg::OPT_KIND_NOP, tcphp_pkg::OPT_KIND_NOP, tcphp_pkg::OPT_KIND_NOP,
                8'd8};
    build_segment(6, 12, 3);
    send_stream(1'b1);
    opt_buf = '{tcphp_pkg::OPT_KIND_MSS, tcphp_pkg::OPT_LEN_MSS, 8'h11, 8'h11,
                tcphp_pkg::OPT_KIND_MSS, tcphp_pkg::OPT_LEN_MSS, 8'h22, 8'h22,
                tcphp_pkg::OPT_KIND_WSCALE, tcphp_pkg::OPT_LEN_WSCALE, 8'd1,
                tcphp_pkg::OPT_KIND_EOL};
    build_segment(8, 12, 0);
    send_stream(1'b1);
    // MSS whose value would run past the header end.
    opt_buf = '{tcphp_pkg::OPT_KIND_NOP, tcphp_pkg::OPT_KIND_MSS, tcphp_pkg::OPT_LEN_MSS,
                8'h40};
    build_segment(6, 12, 0);
    send_stream(1'b1);
    opt_buf = '{tcphp_pkg::OPT_KIND_NOP, tcphp_pkg::OPT_KIND_WSCALE,
                tcphp_pkg::OPT_LEN_WSCALE, 8'd9};
    build_segment(6, 12, 0);
    send_stream(1'b1);
  endtask

  // Pseudo bytes before, among and after segment bytes, with the stream ending on one.
  task automatic test_late_pseudo();
    int k;
    opt_buf.delete();
    build_segment(5, 12, 4);
    for (k = 0; k < pseudo_buf.size(); k++) send_byte(pseudo_buf[k], 1'b1, 1'b0);
    for (k = 0; k < seg_buf.size(); k++) begin
      send_byte(seg_buf[k], 1'b0, 1'b0);
      if (k == 7) send_byte(8'hC3, 1'b1, 1'b0);
    end
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b1);
  endtask

  // The receiver stops for a long stretch while short streams keep coming.
  task automatic test_backpressure();
    hold_cycles = BACKPRESSURE_CYCLES;
    repeat (12) send_noise($urandom_range(1, 3));
    wait_drained();
  endtask

  // Mostly well-formed segments with random content, plus truncated ones, bad
  // header lengths, broken option lists, bad checksums and plain noise.
  task automatic test_random(input int byte_goal, input int seg_goal);
    int b0, s0, pick, nib, cut;
    b0 = bytes_sent;
    s0 = segments_sent;
    while (bytes_sent - b0 < byte_goal || segments_sent - s0 < seg_goal) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        if (pick < 75) nib = $urandom_range(5, ($urandom_range(3) == 0) ? 15 : 8);
        else nib = $urandom_range(0, 4);
        make_options((nib >= 5) ? nib * 4 - int'(tcphp_pkg::HDR_BYTES) : 0,
                     $urandom_range(9) == 0);
        build_segment(nib, ($urandom_range(2) != 0) ? 12 : $urandom_range(0, 13),
                      $urandom_range(0, 9));
        if (pick >= 60 && pick < 75) begin
          cut = $urandom_range(1, seg_buf.size() - 1);
          while (seg_buf.size() > cut) void'(seg_buf.pop_back());
        end
        send_stream($urandom_range(99) < 85);
      end else begin
        send_noise($urandom_range(1, 24));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch in %s of header %0d: expected %0h, got %0h",
                 name, results_checked, want, got);
      end
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare every accepted result beat with the oldest expected header.
  always @(posedge clk) begin : check_results
    tcp_result_t want;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_hdrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with no header expected");
      end else begin
        want = expected_hdrs.pop_front();
        check_field("status", 32'(want.status), 32'(res.status));
        check_field("source_port", 32'(want.source_port), 32'(res.source_port));
        check_field("dst_port", 32'(want.dst_port), 32'(res.dst_port));
        check_field("seq_num", want.seq_num, res.seq_num);
        check_field("ack_num", want.ack_num, res.ack_num);
        check_field("header_len", 32'(want.header_len), 32'(res.header_len));
        check_field("flag_bits", 32'(want.flag_bits), 32'(res.flag_bits));
        check_field("window", 32'(want.window), 32'(res.window));
        check_field("urgent_pointer", 32'(want.urgent_pointer), 32'(res.urgent_pointer));
        check_field("options_seen", 32'(want.options_seen), 32'(res.options_seen));
        check_field("max_seg_size", 32'(want.max_seg_size), 32'(res.max_seg_size));
        check_field("wscale_value", 32'(want.wscale_value), 32'(res.wscale_value));
        results_checked++;
        case (want.status)
          tcphp_pkg::STATUS_OK:      hdr_good++;
          tcphp_pkg::STATUS_HDR_ERR: hdr_bad++;
          default:                   csum_bad++;
        endcase
      end
    end
  end

  // Hang detection: too many cycles in a row with no beat on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst === 1'b1 || (seg.valid === 1'b1 && seg.ready === 1'b1) ||
          (res.valid === 1'b1 && res.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    seg.valid     <= 1'b0;
    seg.data_byte <= '0;
    seg.in_pseudo <= 1'b0;
    seg.last_byte <= 1'b0;
    src_idle_pct    = 35;
    sink_idle_pct   = 66;
    hold_cycles     = 0;
    bytes_sent      = 0;
    segments_sent   = 0;
    results_checked = 0;
    mismatches      = 0;
    hdr_good        = 0;
    hdr_bad         = 0;
    csum_bad        = 0;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_short_and_pseudo();
    test_header_lengths();
    test_options();
    test_late_pseudo();
    test_random(270, 6);
    wait_drained();

    src_idle_pct  = 66;
    sink_idle_pct = 35;
    test_backpressure();
    test_random(270, 6);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(270, 6);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d bytes in %0d segments: option walks, short headers,",
             bytes_sent, segments_sent);
    $display("late pseudo bytes and a long receiver stall; %0d clean, %0d header errors,",
             hdr_good, hdr_bad);
    $display("%0d checksum errors, %0d mismatches.", csum_bad, mismatches);
    if (mismatches == 0 && expected_hdrs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/tcphp_pkg.sv
hw/rtl/tcphp_seg_if.sv
hw/rtl/tcphp_res_if.sv
hw/rtl/tcp_header_option_checksum_parser_unit.sv
test/tb_tcp_header_option_checksum_parser_unit.sv
